### rtl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define LPFP_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpfp checker: property violated");

// Clocked assertion that is also checked during reset.
`define LPFP_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lpfp checker: property violated");

`endif

### rtl/lpfp_pkg.sv
// Types and constants for the length-prefixed field deframer.
package lpfp_pkg;

    localparam int unsigned LEN_BYTES    = 4;
    localparam logic [1:0]  LEN_CNT_LAST = 2'(LEN_BYTES - 1);

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FNUM_W   = 3;
    localparam int unsigned FLEN_W   = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned M_DATA_W = 48;
    localparam int unsigned M_PAD_W  = M_DATA_W - BYTE_W - FNUM_W - FLEN_W - STAT_W;

    typedef enum logic [STAT_W-1:0] {
        STAT_PENDING = 2'd0,
        STAT_ACCEPT  = 2'd1,
        STAT_REJECT  = 2'd2
    } stat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic [FNUM_W-1:0] field_number;
        logic              field_end;
        logic [FLEN_W-1:0] field_length;
        stat_t             payload_status;
    } result_t;

endpackage

### rtl/length_prefixed_field_parser_core.sv
// Top level of the length-prefixed field deframer.
//
// Input stream: one payload byte per request in s_axis_tdata, s_axis_tlast on
// the final byte of the payload. The payload is FIELD_COUNT fields, each a
// 4-byte big-endian length followed by that many body bytes.
// Result stream: exactly one result per input byte. tuser flags a body byte,
// tlast flags the byte that closes a field (zero-length fields close on their
// 4th length byte), tdata carries the byte, field number, declared length and,
// on the payload's last byte, accept or reject.
// Path: the input register holds the request, then the result register takes
// the result after one pass of parse logic.
// Throughput: 1 byte per cycle while the receiver does not stall; the parse state updates once per byte taken.
// Reset (aresetn low, synchronous): both stages empty, parser back to field 0.
// The parser also returns to that state after every last byte.
// Receiver stall: the result register holds, then the input register fills,
// then s_axis_tready drops; nothing is dropped or repeated.
module length_prefixed_field_parser_core #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [10:8] field_number,
                                        // [42:11] field_length, [44:43] payload_status
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] data_valid
);

    logic               item_valid;
    lpfp_pkg::in_item_t item;
    lpfp_pkg::result_t  res;
    logic               room;
    logic               take;

    assign take = item_valid && room;

    lpfp_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    lpfp_parse #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (take),
        .item    (item),
        .res     (res)
    );

    lpfp_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (take),
        .res           (res),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/lpfp_in_stage.sv
// Input register stage: captures one payload byte request.
module lpfp_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  take,
    output logic                  item_valid,
    output lpfp_pkg::in_item_t    item
);

    logic               valid_reg;
    logic               valid_next;
    lpfp_pkg::in_item_t item_reg;
    logic               accept;

    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.byte_in   <= s_axis_tdata;
            item_reg.last_byte <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/lpfp_parse.sv
// Parser state registers and per-byte next-state and result logic.
module lpfp_parse #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  lpfp_pkg::in_item_t  item,
    output lpfp_pkg::result_t   res
);

    localparam int unsigned IDX_W = $clog2(FIELD_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_DONE = IDX_W'(FIELD_COUNT);

    logic                          in_body_reg,  in_body_next;
    logic [1:0]                    cnt_reg,      cnt_next;
    logic [lpfp_pkg::FLEN_W-1:0]   acc_reg,      acc_next;
    logic [lpfp_pkg::FLEN_W-1:0]   rem_reg,      rem_next;
    logic [IDX_W-1:0]              idx_reg,      idx_next;
    logic                          first_reg,    first_next;
    logic                          second_reg,   second_next;
    logic                          err_reg,      err_next;
    logic                          ok;

    always_comb begin
        in_body_next = in_body_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        err_next     = err_reg;

        res.data_byte      = '0;
        res.data_valid     = 1'b0;
        res.field_number   = '0;
        res.field_end      = 1'b0;
        res.field_length   = '0;
        res.payload_status = lpfp_pkg::STAT_PENDING;

        if (err_reg || (idx_reg >= IDX_DONE)) begin
            err_next = 1'b1;
        end else if (!in_body_reg) begin
            res.field_number = lpfp_pkg::FNUM_W'(idx_reg);
            acc_next = {acc_reg[lpfp_pkg::FLEN_W-lpfp_pkg::BYTE_W-1:0], item.byte_in};
            if (cnt_reg == lpfp_pkg::LEN_CNT_LAST) begin
                cnt_next = 2'd0;
                if (idx_reg == IDX_W'(0)) begin
                    first_next = |acc_next;
                end
                if (idx_reg == IDX_W'(1)) begin
                    second_next = |acc_next;
                end
                if (acc_next == '0) begin
                    res.field_end = 1'b1;
                    rem_next      = '0;
                    idx_next      = idx_reg + IDX_W'(1);
                end else begin
                    in_body_next = 1'b1;
                    rem_next     = acc_next;
                end
            end else begin
                cnt_next = cnt_reg + 2'd1;
            end
        end else begin
            res.field_number = lpfp_pkg::FNUM_W'(idx_reg);
            res.data_byte    = item.byte_in;
            res.data_valid   = 1'b1;
            rem_next         = rem_reg - 32'd1;
            if (rem_next == '0) begin
                res.field_end    = 1'b1;
                res.field_length = acc_reg;
                in_body_next     = 1'b0;
                cnt_next         = 2'd0;
                idx_next         = idx_reg + IDX_W'(1);
            end
        end

        ok = !err_next && (idx_next == IDX_DONE) && !in_body_next && (cnt_next == 2'd0)
             && first_next && ((FIELD_COUNT < 2) || second_next);

        if (item.last_byte) begin
            res.payload_status = ok ? lpfp_pkg::STAT_ACCEPT : lpfp_pkg::STAT_REJECT;
            in_body_next = 1'b0;
            cnt_next     = 2'd0;
            acc_next     = '0;
            rem_next     = '0;
            idx_next     = '0;
            first_next   = 1'b0;
            second_next  = 1'b0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            acc_reg     <= '0;
            rem_reg     <= '0;
            idx_reg     <= '0;
            first_reg   <= 1'b0;
            second_reg  <= 1'b0;
            err_reg     <= 1'b0;
        end else if (advance) begin
            in_body_reg <= in_body_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            idx_reg     <= idx_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            err_reg     <= err_next;
        end
    end

endmodule

### rtl/lpfp_out_stage.sv
// Result register stage driving the result stream.
module lpfp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lpfp_pkg::result_t res,
    output logic              room,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);

    logic              valid_reg;
    logic              valid_next;
    lpfp_pkg::result_t res_reg;

    assign room = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{lpfp_pkg::M_PAD_W{1'b0}}, res_reg.payload_status,
                            res_reg.field_length, res_reg.field_number, res_reg.data_byte};
    assign m_axis_tlast  = res_reg.field_end;
    assign m_axis_tuser  = res_reg.data_valid;

endmodule

### rtl/lpfp_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module lpfp_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    logic stall;
    logic len_res;
    logic idle_res;
    logic stat_bad;

    assign stall    = m_axis_tvalid && !m_axis_tready;
    assign len_res  = m_axis_tvalid && (m_axis_tdata[42:11] != 32'd0);
    assign idle_res = m_axis_tvalid && !m_axis_tuser;
    assign stat_bad = m_axis_tdata[44:43] == 2'd3;

    `LPFP_ASSERT(a_reset_empties_output, aclk, !aresetn |=> !m_axis_tvalid)
    `LPFP_ASSERT_RST(a_stall_holds, aclk, aresetn, stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    `LPFP_ASSERT_RST(a_status_code, aclk, aresetn, m_axis_tvalid |-> !stat_bad)
    `LPFP_ASSERT_RST(a_length_only_at_end, aclk, aresetn, len_res |-> m_axis_tlast)
    `LPFP_ASSERT_RST(a_idle_byte_zero, aclk, aresetn, idle_res |-> m_axis_tdata[7:0] == 8'd0)

endmodule

bind length_prefixed_field_parser_core lpfp_port_checker u_lpfp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
